FILE: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and codes for the three-wire serial bus master.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned BIT_W   = 3;
	localparam int unsigned PHASE_W = 3;

	localparam logic [BYTE_W-1:0] HALF_RESET = 8'd2;
	localparam logic [BIT_W-1:0]  LAST_BIT   = 3'd7;

	// sequencer phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CMD_HI = 3'd1;
	localparam logic [PHASE_W-1:0] PH_CMD_LO = 3'd2;
	localparam logic [PHASE_W-1:0] PH_WR_HI  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_WR_LO  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_TURN   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_RD_HI  = 3'd6;
	localparam logic [PHASE_W-1:0] PH_RD_LO  = 3'd7;

	typedef struct packed {
		logic              start_req;
		logic              req_type;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] write_data;
		logic              io_in;
	} item_t;

	typedef struct packed {
		logic              enable_out;
		logic              sclk_out;
		logic              io_out;
		logic              io_drive;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
	} result_t;

endpackage

FILE: rtl/tws_in_stage.sv
// ----------------------------------------------------------------------------
// tws_in_stage
// Input register: holds one tick word until the sequencer takes it.
// ----------------------------------------------------------------------------
module tws_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tws_pkg::item_t  item,
	output logic            valid_s1,
	output tws_pkg::item_t  item_s1,
	input  logic            take
);

	logic valid_q;

	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

FILE: rtl/tws_seq.sv
// ----------------------------------------------------------------------------
// tws_seq
// Bus sequencer: phase, bit and tick counters, shift bytes and the
// half-period register; computes the pin levels for each tick word.
// ----------------------------------------------------------------------------
module tws_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tws_pkg::BYTE_W-1:0]   cfg_data,
	input  logic                         step,
	input  tws_pkg::item_t               item_s1,
	output tws_pkg::result_t             res
);

	logic [tws_pkg::BYTE_W-1:0]  half_q;
	logic [tws_pkg::PHASE_W-1:0] phase_q, phase_n;
	logic [tws_pkg::BIT_W-1:0]   bit_q, bit_n;
	logic [tws_pkg::BYTE_W-1:0]  tick_q, tick_n;
	logic [tws_pkg::BYTE_W-1:0]  cmd_q, cmd_n;
	logic [tws_pkg::BYTE_W-1:0]  data_q, data_n;
	logic                        is_read_q, is_read_n;
	logic [tws_pkg::BYTE_W-1:0]  rbyte_q, rbyte_n;
	logic [tws_pkg::BYTE_W-1:0]  eff_half;
	logic                        done;

	// a half period of zero runs as one
	assign eff_half = (half_q == '0) ? tws_pkg::BYTE_W'(1) : half_q;

	always_comb begin
		phase_n   = phase_q;
		bit_n     = bit_q;
		tick_n    = tick_q;
		cmd_n     = cmd_q;
		data_n    = data_q;
		is_read_n = is_read_q;
		rbyte_n   = rbyte_q;
		done      = 1'b0;
		if (phase_q == tws_pkg::PH_IDLE) begin
			if (item_s1.start_req) begin
				cmd_n     = item_s1.command;
				data_n    = item_s1.write_data;
				is_read_n = item_s1.req_type;
				bit_n     = '0;
				phase_n   = tws_pkg::PH_CMD_HI;
				tick_n    = tws_pkg::BYTE_W'(1);
			end
		end else if (tick_q < eff_half) begin
			tick_n = tick_q + tws_pkg::BYTE_W'(1);
		end else begin
			tick_n = tws_pkg::BYTE_W'(1);
			case (phase_q)
				tws_pkg::PH_CMD_HI: phase_n = tws_pkg::PH_CMD_LO;
				tws_pkg::PH_WR_HI:  phase_n = tws_pkg::PH_WR_LO;
				tws_pkg::PH_RD_HI:  phase_n = tws_pkg::PH_RD_LO;
				tws_pkg::PH_CMD_LO: begin
					if (bit_q != tws_pkg::LAST_BIT) begin
						bit_n   = bit_q + tws_pkg::BIT_W'(1);
						phase_n = tws_pkg::PH_CMD_HI;
					end else begin
						bit_n = '0;
						if (is_read_q) begin
							data_n  = '0;
							phase_n = tws_pkg::PH_TURN;
						end else begin
							phase_n = tws_pkg::PH_WR_HI;
						end
					end
				end
				tws_pkg::PH_WR_LO: begin
					if (bit_q != tws_pkg::LAST_BIT) begin
						bit_n   = bit_q + tws_pkg::BIT_W'(1);
						phase_n = tws_pkg::PH_WR_HI;
					end else begin
						bit_n   = '0;
						phase_n = tws_pkg::PH_IDLE;
						tick_n  = '0;
						done    = 1'b1;
					end
				end
				tws_pkg::PH_TURN: begin
					data_n[bit_q] = data_q[bit_q] | item_s1.io_in;
					phase_n       = tws_pkg::PH_RD_HI;
				end
				default: begin
					// low half of a read bit
					if (bit_q != tws_pkg::LAST_BIT) begin
						bit_n         = bit_q + tws_pkg::BIT_W'(1);
						data_n[bit_n] = data_q[bit_n] | item_s1.io_in;
						phase_n       = tws_pkg::PH_RD_HI;
					end else begin
						bit_n   = '0;
						rbyte_n = data_q;
						phase_n = tws_pkg::PH_IDLE;
						tick_n  = '0;
						done    = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		res            = '0;
		res.busy_res   = (phase_n != tws_pkg::PH_IDLE);
		res.enable_out = res.busy_res;
		res.done_res   = done;
		res.read_data  = rbyte_n;
		res.sclk_out   = (phase_n == tws_pkg::PH_CMD_HI) || (phase_n == tws_pkg::PH_WR_HI)
			|| (phase_n == tws_pkg::PH_RD_HI);
		if ((phase_n == tws_pkg::PH_CMD_HI) || (phase_n == tws_pkg::PH_CMD_LO)) begin
			res.io_drive = 1'b1;
			res.io_out   = cmd_n[bit_n];
		end else if ((phase_n == tws_pkg::PH_WR_HI) || (phase_n == tws_pkg::PH_WR_LO)) begin
			res.io_drive = 1'b1;
			res.io_out   = data_n[bit_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= tws_pkg::HALF_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tws_pkg::PH_IDLE;
			bit_q     <= '0;
			tick_q    <= '0;
			cmd_q     <= '0;
			data_q    <= '0;
			is_read_q <= 1'b0;
			rbyte_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			bit_q     <= bit_n;
			tick_q    <= tick_n;
			cmd_q     <= cmd_n;
			data_q    <= data_n;
			is_read_q <= is_read_n;
			rbyte_q   <= rbyte_n;
		end
	end

endmodule

FILE: rtl/tws_out_stage.sv
// ----------------------------------------------------------------------------
// tws_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module tws_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tws_pkg::result_t  res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output tws_pkg::result_t  res_q
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: rtl/three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_serial_master
// Three-wire serial bus master, LSB first; one input word per timing tick.
// ----------------------------------------------------------------------------
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | in_valid/in_ready, start_req .. io_in     | into block
// out      | out_valid/out_ready, enable_out .. read_d | out of block
// cfg      | cfg_valid/cfg_ready, cfg_data             | into block
//
// one word per clock sustained while the output is not stalled; an accepted
// word goes via the input register and sequencer into the result register
// reset puts the bus idle with a half period of two ticks
// a stalled output holds the sequencer and, one word later, the input side
// cfg is always ready and takes effect on the next sequencer step
// ----------------------------------------------------------------------------
module three_wire_serial_master (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        start_req,
	input  logic                        req_type,
	input  logic [tws_pkg::BYTE_W-1:0]  command,
	input  logic [tws_pkg::BYTE_W-1:0]  write_data,
	input  logic                        io_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        enable_out,
	output logic                        sclk_out,
	output logic                        io_out,
	output logic                        io_drive,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [tws_pkg::BYTE_W-1:0]  read_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tws_pkg::BYTE_W-1:0]  cfg_data
);

	tws_pkg::item_t   item, item_s1;
	tws_pkg::result_t res, res_q;
	logic             valid_s1;
	logic             free;
	logic             step;

	assign cfg_ready = 1'b1;

	assign item.start_req  = start_req;
	assign item.req_type   = req_type;
	assign item.command    = command;
	assign item.write_data = write_data;
	assign item.io_in      = io_in;

	assign step = valid_s1 && free;

	tws_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (step)
	);

	tws_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.step     (step),
		.item_s1  (item_s1),
		.res      (res)
	);

	tws_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign enable_out = res_q.enable_out;
	assign sclk_out   = res_q.sclk_out;
	assign io_out     = res_q.io_out;
	assign io_drive   = res_q.io_drive;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign read_data  = res_q.read_data;

endmodule

FILE: rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks on the serial master, attached to the top level.
// ----------------------------------------------------------------------------
module tws_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        enable_out,
	input logic                        sclk_out,
	input logic                        io_out,
	input logic                        io_drive,
	input logic                        busy_res,
	input logic                        done_res,
	input logic [tws_pkg::BYTE_W-1:0]  read_data
);

	// a stalled result word holds its read data and done flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(done_res))
		else $error("result word changed while stalled");

	// the finishing word already shows the bus idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !enable_out && !sclk_out && !io_drive)
		else $error("done with bus still active");

	// released data pin is driven low in the result
	a_io_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !io_drive |-> !io_out)
		else $error("io_out high while released");

	// clock and data drive only inside a transaction
	a_bus_in_txn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sclk_out || io_drive) |-> enable_out && busy_res)
		else $error("bus activity outside a transaction");

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.enable_out (enable_out),
	.sclk_out   (sclk_out),
	.io_out     (io_out),
	.io_drive   (io_drive),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.read_data  (read_data)
);
